FILE: rtl/core/assert_macros.svh
// assertion helpers shared by the core modules
// all of them sample on clk and are held off while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Types and codes shared by the preemptive priority scheduler core.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int TIME_W = 16;
  localparam int BURST_W = 8;
  localparam int PRIO_W = 8;
  localparam int SLOT_FIELD_W = 4;
  localparam int CFG_DATA_W = 8;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // configuration register indexes
  localparam logic REG_DESCENDING = 1'b0;
  localparam logic REG_OVERHEAD = 1'b1;

  typedef struct packed {
    logic                    operation;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [TIME_W-1:0]       arrival_time;
    logic [BURST_W-1:0]      burst_time;
    logic [PRIO_W-1:0]       priority_level;
  } item_t;

  typedef struct packed {
    logic                    ran_valid;
    logic [SLOT_FIELD_W-1:0] ran_slot;
    logic                    in_overhead;
    logic                    completed;
    logic [TIME_W-1:0]       finish_time;
    logic [TIME_W-1:0]       turnaround_time;
    logic [TIME_W-1:0]       waiting_time;
    logic                    all_done;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic item_latch;
    logic load_wr;
    logic ovh_step;
    logic scan_init;
    logic scan_run;
    logic upd;
    logic calc;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op_tick;
    logic ovh_pending;
    logic scan_done;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/core/pps_ctrl.sv
// ----------------------------------------------------------------------------
// pps_ctrl
// Sequencer for the scheduler: takes a request, steps the datapath through
// load, overhead or scan/update/calc, then hands the result to the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pps_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  pps_pkg::status_t status,
  output pps_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_OVH  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_CALC = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.item_latch = 1'b1;
          if (!status.op_tick) begin
            state_next = S_LOAD;
          end else if (status.ovh_pending) begin
            state_next = S_OVH;
          end else begin
            cmd.scan_init = 1'b1;
            state_next = S_SCAN;
          end
        end
      end
      S_LOAD: begin
        cmd.load_wr = 1'b1;
        state_next = S_EMIT;
      end
      S_OVH: begin
        cmd.ovh_step = 1'b1;
        state_next = S_EMIT;
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (status.scan_done) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        state_next = S_CALC;
      end
      S_CALC: begin
        cmd.calc = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `ASSERT_NEXT(a_scan_ends_in_update, (state == S_SCAN) && status.scan_done, state == S_UPD)
  `ASSERT_NEXT(a_emit_waits_for_output, (state == S_EMIT) && !status.out_free, state == S_EMIT)
  `ASSERT_NEXT(a_tick_starts_scan,
               (state == S_IDLE) && item_valid && status.op_tick && !status.ovh_pending,
               state == S_SCAN)

endmodule

FILE: rtl/core/pps_datapath.sv
// ----------------------------------------------------------------------------
// pps_datapath
// Process table, slot scan and compare, time keeping, result assembly and
// the output register of the scheduler.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pps_datapath #(
  parameter int MAX_PROCESSES = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pps_pkg::item_t                      item,
  input  logic                                cfg_valid,
  input  logic                                cfg_index,
  input  logic [pps_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                result_ready,
  output logic                                result_valid,
  output pps_pkg::result_t                    result,
  input  pps_pkg::cmd_t                       cmd,
  output pps_pkg::status_t                    status
);

  localparam int SLOT_W = $clog2(MAX_PROCESSES);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_PROCESSES - 1);

  // process table
  logic [pps_pkg::TIME_W-1:0]  arr_mem [MAX_PROCESSES];
  logic [pps_pkg::BURST_W-1:0] bur_mem [MAX_PROCESSES];
  logic [pps_pkg::PRIO_W-1:0]  pri_mem [MAX_PROCESSES];
  logic [pps_pkg::BURST_W-1:0] rem_mem [MAX_PROCESSES];

  logic [MAX_PROCESSES-1:0] loaded;
  logic [MAX_PROCESSES-1:0] work;

  logic                        desc_order;
  logic [pps_pkg::BURST_W-1:0] ovh_ticks;
  logic [pps_pkg::TIME_W-1:0]  cur_time;
  logic [pps_pkg::BURST_W-1:0] ovh_left;

  pps_pkg::item_t   held_item;
  pps_pkg::result_t res;
  pps_pkg::result_t res_out;

  // scan pipeline
  logic [SLOT_W-1:0]           idx;
  logic                        issuing;
  logic                        data_vld;
  logic [SLOT_W-1:0]           data_slot;
  logic [pps_pkg::TIME_W-1:0]  rd_arr;
  logic [pps_pkg::BURST_W-1:0] rd_bur;
  logic [pps_pkg::PRIO_W-1:0]  rd_pri;
  logic [pps_pkg::BURST_W-1:0] rd_rem;

  logic                        best_found;
  logic [SLOT_W-1:0]           best_slot;
  logic [pps_pkg::TIME_W-1:0]  best_arr;
  logic [pps_pkg::BURST_W-1:0] best_bur;
  logic [pps_pkg::PRIO_W-1:0]  best_pri;
  logic [pps_pkg::BURST_W-1:0] best_rem;

  logic [SLOT_W-1:0]           load_slot;
  logic                        load_in_range;
  logic                        load_we;
  logic                        finishing;
  logic                        rem_we;
  logic [SLOT_W-1:0]           rem_addr;
  logic [pps_pkg::BURST_W-1:0] rem_wd;
  logic                        eligible;
  logic                        prio_better;
  logic                        take;
  logic                        issue;
  logic [pps_pkg::TIME_W-1:0]  time_inc;
  logic [pps_pkg::TIME_W:0]    fin_sum;
  logic [pps_pkg::TIME_W-1:0]  fin;
  logic [pps_pkg::TIME_W:0]    tat_diff;
  logic [pps_pkg::TIME_W+1:0]  wt_diff;

  assign load_slot     = SLOT_W'(held_item.slot);
  assign load_in_range = (32'(held_item.slot) < MAX_PROCESSES);
  assign load_we       = cmd.load_wr && load_in_range;
  assign finishing     = best_found && (best_rem == pps_pkg::BURST_W'(1));
  assign issue         = cmd.scan_run && issuing;

  assign rem_we   = load_we || (cmd.upd && best_found);
  assign rem_addr = cmd.load_wr ? load_slot : best_slot;
  assign rem_wd   = cmd.load_wr ? held_item.burst_time : best_rem - pps_pkg::BURST_W'(1);

  assign eligible = data_vld && work[data_slot] && (rd_arr <= cur_time);
  assign prio_better = desc_order ? (rd_pri > best_pri) : (rd_pri < best_pri);
  assign take = eligible &&
                (!best_found || prio_better || ((rd_pri == best_pri) && (rd_bur < best_bur)));

  assign time_inc = (cur_time == pps_pkg::TIME_MAX) ? cur_time
                                                    : cur_time + pps_pkg::TIME_W'(1);
  // finish time saturates at the top of the time range
  assign fin_sum = (pps_pkg::TIME_W+1)'(cur_time) + (pps_pkg::TIME_W+1)'(ovh_ticks)
                 + (pps_pkg::TIME_W+1)'(1);
  assign fin = fin_sum[pps_pkg::TIME_W] ? pps_pkg::TIME_MAX : fin_sum[pps_pkg::TIME_W-1:0];

  assign tat_diff = (pps_pkg::TIME_W+1)'(res.finish_time) - (pps_pkg::TIME_W+1)'(best_arr);
  assign wt_diff  = (pps_pkg::TIME_W+2)'(res.finish_time) - (pps_pkg::TIME_W+2)'(best_arr)
                  - (pps_pkg::TIME_W+2)'(best_bur);

  assign status.op_tick     = (item.operation == pps_pkg::OP_TICK);
  assign status.ovh_pending = (ovh_left != '0);
  assign status.scan_done   = data_vld && (data_slot == LAST_SLOT);
  assign status.out_free    = !result_valid || result_ready;

  // done flag reflects the table after this request's update
  always_comb begin
    res_out          = res;
    res_out.all_done = (|loaded) && !(|work);
  end

  // table writes
  always_ff @(posedge clk) begin
    if (load_we) begin
      arr_mem[load_slot] <= held_item.arrival_time;
      bur_mem[load_slot] <= held_item.burst_time;
      pri_mem[load_slot] <= held_item.priority_level;
    end
    if (rem_we) begin
      rem_mem[rem_addr] <= rem_wd;
    end
  end

  // table reads, one slot per cycle
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_arr    <= arr_mem[idx];
      rd_bur    <= bur_mem[idx];
      rd_pri    <= pri_mem[idx];
      rd_rem    <= rem_mem[idx];
      data_slot <= idx;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded       <= '0;
      work         <= '0;
      desc_order   <= 1'b0;
      ovh_ticks    <= '0;
      cur_time     <= '0;
      ovh_left     <= '0;
      issuing      <= 1'b0;
      data_vld     <= 1'b0;
      best_found   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          pps_pkg::REG_DESCENDING: desc_order <= cfg_data[0];
          pps_pkg::REG_OVERHEAD:   ovh_ticks <= cfg_data;
          default:                 desc_order <= desc_order;
        endcase
      end

      if (load_we) begin
        loaded[load_slot] <= 1'b1;
        work[load_slot]   <= (held_item.burst_time != '0);
      end

      if (cmd.ovh_step) begin
        ovh_left <= ovh_left - pps_pkg::BURST_W'(1);
        cur_time <= time_inc;
      end

      if (cmd.upd) begin
        cur_time <= time_inc;
        if (finishing) begin
          work[best_slot] <= 1'b0;
          ovh_left <= ovh_ticks;
        end
      end

      if (cmd.scan_init) begin
        issuing    <= 1'b1;
        data_vld   <= 1'b0;
        best_found <= 1'b0;
      end else begin
        data_vld <= issue;
        if (issue && (idx == LAST_SLOT)) begin
          issuing <= 1'b0;
        end
        if (take) begin
          best_found <= 1'b1;
        end
      end

      result_valid <= cmd.emit || (result_valid && !result_ready);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.item_latch) begin
      held_item <= item;
      res       <= '0;
    end
    if (cmd.scan_init) begin
      idx <= '0;
    end else if (issue) begin
      idx <= idx + SLOT_W'(1);
    end
    if (take) begin
      best_slot <= data_slot;
      best_arr  <= rd_arr;
      best_bur  <= rd_bur;
      best_pri  <= rd_pri;
      best_rem  <= rd_rem;
    end
    if (cmd.ovh_step) begin
      res.in_overhead <= 1'b1;
    end
    if (cmd.upd && best_found) begin
      res.ran_valid <= 1'b1;
      res.ran_slot  <= pps_pkg::SLOT_FIELD_W'(best_slot);
      if (finishing) begin
        res.completed   <= 1'b1;
        res.finish_time <= fin;
      end
    end
    if (cmd.calc && res.completed) begin
      res.turnaround_time <= tat_diff[pps_pkg::TIME_W] ? '0 : tat_diff[pps_pkg::TIME_W-1:0];
      res.waiting_time    <= (tat_diff[pps_pkg::TIME_W] || wt_diff[pps_pkg::TIME_W+1]) ? '0
                             : wt_diff[pps_pkg::TIME_W-1:0];
    end
    if (cmd.emit) begin
      result <= res_out;
    end
  end

  `ASSERT_NOW(a_work_only_on_loaded, 1'b1, (work & ~loaded) == '0)
  `ASSERT_NOW(a_completion_has_runner, result_valid && result.completed, result.ran_valid)
  `ASSERT_NOW(a_overhead_runs_nothing, result_valid && result.in_overhead,
              !result.ran_valid && !result.completed)

endmodule

FILE: rtl/core/preemptive_priority_scheduler_core.sv
// A load request writes one process slot (arrival, burst, priority) if the slot
// is below MAX_PROCESSES; a tick request during switch overhead takes one overhead
// step. A tick request that schedules goes through scan, update and calc: the
// process table is a single-read-port memory and the scan reads one slot per cycle,
// keeping the best eligible entry (best priority, then shorter burst, then lower slot).
// Each request yields exactly one result; a result held in the output register
// does not stop the next request from being accepted and worked on.
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_core
// Top level: controller and datapath of the preemptive priority scheduler.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_core #(
  parameter int MAX_PROCESSES = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  pps_pkg::item_t                 item,
  output logic                           result_valid,
  input  logic                           result_ready,
  output pps_pkg::result_t               result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [pps_pkg::CFG_DATA_W-1:0] cfg_data
);

  pps_pkg::cmd_t    cmd;
  pps_pkg::status_t status;

  // registers are to be written only while idle (the user's rule; the block does not enforce it), so writes never stall
  assign cfg_ready = 1'b1;

  pps_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  pps_datapath #(
    .MAX_PROCESSES (MAX_PROCESSES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .result       (result),
    .cmd          (cmd),
    .status       (status)
  );

endmodule
